### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PLT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Types, token codes and the keyword table of the Pascal-like tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plt_pkg;

    localparam int KEYWORD_MAX_LEN_DEF = 10;
    localparam int FRACTION_DIGITS_DEF = 9;
    localparam int VALUE_WIDTH_DEF     = 32;

    localparam int KW_COUNT = 49;
    localparam int KW_CHARS = 10;

    // Token codes
    localparam logic [6:0] TOK_IDENT  = 7'd0;
    localparam logic [6:0] TOK_NUMB   = 7'd1;
    localparam logic [6:0] TOK_NUMBR  = 7'd2;
    localparam logic [6:0] TOK_STRING = 7'd3;
    localparam logic [6:0] TOK_PLUS   = 7'd5;
    localparam logic [6:0] TOK_MINUS  = 7'd6;
    localparam logic [6:0] TOK_STAR   = 7'd7;
    localparam logic [6:0] TOK_SLASH  = 7'd8;
    localparam logic [6:0] TOK_LT     = 7'd9;
    localparam logic [6:0] TOK_LE     = 7'd10;
    localparam logic [6:0] TOK_GT     = 7'd11;
    localparam logic [6:0] TOK_GE     = 7'd12;
    localparam logic [6:0] TOK_ASSIGN = 7'd13;
    localparam logic [6:0] TOK_DOT    = 7'd14;
    localparam logic [6:0] TOK_EOI    = 7'd29;
    localparam logic [6:0] TOK_ERR    = 7'd30;
    localparam logic [6:0] TOK_COMMA  = 7'd52;
    localparam logic [6:0] TOK_EQ     = 7'd53;
    localparam logic [6:0] TOK_LPAREN = 7'd54;
    localparam logic [6:0] TOK_RPAREN = 7'd55;
    localparam logic [6:0] TOK_COLON  = 7'd56;
    localparam logic [6:0] TOK_RBRACK = 7'd59;
    localparam logic [6:0] TOK_LBRACK = 7'd60;
    localparam logic [6:0] TOK_NE     = 7'd70;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR    = 3'd1;
    localparam logic [2:0] ERR_EOF_COMMENT = 3'd2;
    localparam logic [2:0] ERR_BAD_CESC    = 3'd3;
    localparam logic [2:0] ERR_BAD_DIGIT   = 3'd4;
    localparam logic [2:0] ERR_REAL_BASE   = 3'd5;
    localparam logic [2:0] ERR_OPEN_STRING = 3'd6;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_COMMENT, MODE_CESC, MODE_IDENT, MODE_NUMBER, MODE_REAL,
        MODE_DOT, MODE_LESS, MODE_GREATER, MODE_COLON, MODE_STRING, MODE_SESC
    } scan_mode_t;

    typedef enum logic [1:0] {
        BASE_OCT, BASE_DEC, BASE_HEX
    } base_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } plt_in_t;

    typedef struct packed {
        logic        is_text;
        logic [7:0]  text_char;
        logic [6:0]  token_type;
        logic [31:0] int_value;
        logic [29:0] frac_value;
        logic [3:0]  frac_digits;
        logic [2:0]  error_code;
        logic        last;
    } plt_out_t;

    // Keyword spelling, first character in the highest used byte
    localparam logic [KW_CHARS*8-1:0] KW_WORD [KW_COUNT] = '{
        "if", "then", "else", "for", "do", "while", "var", "program", "uses",
        "const", "function", "begin", "end", "procedure", "and", "div", "file",
        "forward", "in", "exit", "of", "type", "label", "or", "repeat", "until",
        "downto", "mod", "packed", "set", "declare", "info", "assert", "case",
        "check", "get", "goto", "nil", "not", "to", "with", "integer", "real",
        "character", "boolean", "enumerator", "array", "pointer", "distinct"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd4, 4'd3, 4'd2, 4'd5, 4'd3, 4'd7, 4'd4,
        4'd5, 4'd8, 4'd5, 4'd3, 4'd9, 4'd3, 4'd3, 4'd4,
        4'd7, 4'd2, 4'd4, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5,
        4'd6, 4'd3, 4'd6, 4'd3, 4'd7, 4'd4, 4'd6, 4'd4,
        4'd5, 4'd3, 4'd4, 4'd3, 4'd3, 4'd2, 4'd4, 4'd7, 4'd4,
        4'd9, 4'd7, 4'd10, 4'd5, 4'd7, 4'd8
    };

    localparam logic [6:0] KW_CODE [KW_COUNT] = '{
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd31, 7'd22, 7'd23,
        7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd32, 7'd33, 7'd34,
        7'd69, 7'd35, 7'd71, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41,
        7'd42, 7'd43, 7'd44, 7'd45, 7'd73, 7'd72, 7'd74, 7'd46,
        7'd75, 7'd76, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd61, 7'd62,
        7'd63, 7'd64, 7'd65, 7'd67, 7'd68, 7'd77
    };

    // Match the held identifier against all keywords in parallel.
    // chars holds character j at bits [8j+7:8j].
    function automatic logic [6:0] kw_lookup(input logic [KW_CHARS*8-1:0] chars,
                                             input logic [4:0] len);
        logic [6:0] code;
        logic       hit;
        int         k;
        code = TOK_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            hit = ({1'b0, KW_LEN[i]} == len);
            for (int j = 0; j < KW_CHARS; j++)
            begin
                k = int'(KW_LEN[i]) - 1 - j;
                if (k >= 0)
                begin
                    if (chars[8*j +: 8] != KW_WORD[i][8*k +: 8])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit)
            begin
                code = KW_CODE[i];
            end
        end
        return code;
    endfunction

endpackage

### rtl/plt_scan.sv
// ----------------------------------------------------------------------------
// plt_scan
// Scanner state and the single-pass step that turns one item into up to two
// results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_scan
    import plt_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  plt_in_t  item,
    output plt_out_t res0,
    output plt_out_t res1,
    output logic [1:0] res_count
);

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int IW = $clog2(KEYWORD_MAX_LEN);
    localparam int VW = VALUE_WIDTH;

    scan_mode_t  mode_reg, mode_next;
    base_t       base_reg, base_next;
    logic [VW-1:0] value_reg, value_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [LW-1:0] len_reg, len_next;
    logic        quote_reg, quote_next;
    logic [7:0]  kw_buf_reg [KEYWORD_MAX_LEN];

    logic          buf_we;
    logic [IW-1:0] buf_wa;

    logic [7:0] c;
    logic       e;
    logic       is_let, is_dig;
    logic [5:0] digit;
    logic [4:0] radix;
    logic [VW+4:0] wide;
    logic [33:0] frac_wide;
    logic [29:0] frac_add;
    logic [3:0]  fcnt_add;
    logic [KW_CHARS*8-1:0] kw_chars;
    logic [6:0] kw_code;

    scan_mode_t idle_mode;
    logic       idle_emit;
    plt_out_t   idle_res;
    logic       idle_quote_we, idle_quote;
    logic       idle_ident, idle_num;
    base_t      idle_base;
    logic [VW-1:0] idle_value;

    logic     p_v, p2_v, go_idle;
    plt_out_t p_res, p2_res;
    logic     v0, v1;

    function automatic plt_out_t mk_tok(input logic [6:0] t);
        plt_out_t r;
        r = '0;
        r.token_type = t;
        return r;
    endfunction

    function automatic plt_out_t mk_text(input logic [6:0] t, input logic [7:0] ch);
        plt_out_t r;
        r = '0;
        r.is_text    = 1'b1;
        r.text_char  = ch;
        r.token_type = t;
        return r;
    endfunction

    function automatic plt_out_t mk_err(input logic [2:0] code);
        plt_out_t r;
        r = '0;
        r.token_type = TOK_ERR;
        r.error_code = code;
        return r;
    endfunction

    assign c = item.in_byte;
    assign e = item.end_of_input;

    // Classify the character and its digit value
    assign is_let = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c == "_");
    assign is_dig = (c >= "0" && c <= "9");

    always_comb
    begin
        if (c >= "a")
        begin
            digit = 6'(c - 8'd87);
        end
        else if (c >= "A")
        begin
            digit = 6'(c - 8'd55);
        end
        else
        begin
            digit = 6'(c - "0");
        end
    end

    always_comb
    begin
        unique case (base_reg)
            BASE_OCT: radix = 5'd8;
            BASE_HEX: radix = 5'd16;
            default:  radix = 5'd10;
        endcase
    end

    // Accumulate one digit: shifts and adds for the three radixes
    always_comb
    begin
        unique case (base_reg)
            BASE_OCT: wide = {value_reg, 3'b000} + (VW+5)'(digit);
            BASE_HEX: wide = {1'b0, value_reg, 4'b0000} + (VW+5)'(digit);
            default:  wide = {1'b0, value_reg, 4'b0000} - {2'b00, value_reg, 3'b000}
                             + {4'b0000, value_reg, 1'b0} + (VW+5)'(digit);
        endcase
    end

    // Fraction digit, kept only while below the digit limit
    assign frac_wide = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0} + 34'(c - "0");
    always_comb
    begin
        if (32'(fcnt_reg) < FRACTION_DIGITS)
        begin
            frac_add = frac_wide[29:0];
            fcnt_add = fcnt_reg + 4'd1;
        end
        else
        begin
            frac_add = frac_reg;
            fcnt_add = fcnt_reg;
        end
    end

    // Keyword match on the held identifier
    always_comb
    begin
        for (int j = 0; j < KW_CHARS; j++)
        begin
            kw_chars[8*j +: 8] = kw_buf_reg[j];
        end
    end
    assign kw_code = (32'(len_reg) > KEYWORD_MAX_LEN) ? TOK_IDENT
                   : kw_lookup(kw_chars, 5'(len_reg));

    // Scan from the idle mode
    always_comb
    begin
        idle_mode     = MODE_IDLE;
        idle_emit     = 1'b0;
        idle_res      = '0;
        idle_quote_we = 1'b0;
        idle_quote    = 1'b0;
        idle_ident    = 1'b0;
        idle_num      = 1'b0;
        idle_base     = BASE_DEC;
        idle_value    = '0;
        if (e)
        begin
            idle_emit = 1'b1;
            idle_res  = mk_tok(TOK_EOI);
        end
        else
        begin
            case (c)
                "{": idle_mode = MODE_COMMENT;
                "[":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_LBRACK);
                end
                "]":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_RBRACK);
                end
                "&":
                begin
                    idle_num  = 1'b1;
                    idle_base = BASE_OCT;
                    idle_mode = MODE_NUMBER;
                end
                "$":
                begin
                    idle_num  = 1'b1;
                    idle_base = BASE_HEX;
                    idle_mode = MODE_NUMBER;
                end
                "(":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_LPAREN);
                end
                ")":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_RPAREN);
                end
                "+":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_PLUS);
                end
                "-":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_MINUS);
                end
                "*":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_STAR);
                end
                "/":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_SLASH);
                end
                ",":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_COMMA);
                end
                "=":
                begin
                    idle_emit = 1'b1;
                    idle_res  = mk_tok(TOK_EQ);
                end
                "<": idle_mode = MODE_LESS;
                ">": idle_mode = MODE_GREATER;
                ":": idle_mode = MODE_COLON;
                ".": idle_mode = MODE_DOT;
                "'":
                begin
                    idle_quote_we = 1'b1;
                    idle_quote    = 1'b0;
                    idle_mode     = MODE_STRING;
                end
                "\"":
                begin
                    idle_quote_we = 1'b1;
                    idle_quote    = 1'b1;
                    idle_mode     = MODE_STRING;
                end
                default:
                begin
                    if (is_let)
                    begin
                        idle_ident = 1'b1;
                        idle_emit  = 1'b1;
                        idle_res   = mk_text(TOK_IDENT, c);
                        idle_mode  = MODE_IDENT;
                    end
                    else if (is_dig)
                    begin
                        idle_num   = 1'b1;
                        idle_value = VW'(c - "0");
                        idle_mode  = MODE_NUMBER;
                    end
                    else if (c <= 8'd32 || c == "|" || c == ";")
                    begin
                        idle_mode = MODE_IDLE;
                    end
                    else
                    begin
                        idle_emit = 1'b1;
                        idle_res  = mk_err(ERR_BAD_CHAR);
                    end
                end
            endcase
        end
    end

    // Next state and results for the current mode
    always_comb
    begin
        mode_next  = mode_reg;
        base_next  = base_reg;
        value_next = value_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        len_next   = len_reg;
        quote_next = quote_reg;
        buf_we     = 1'b0;
        buf_wa     = len_reg[IW-1:0];
        p_v        = 1'b0;
        p_res      = '0;
        p2_v       = 1'b0;
        p2_res     = '0;
        go_idle    = 1'b0;

        unique case (mode_reg)
            MODE_COMMENT:
            begin
                if (e)
                begin
                    p_v = 1'b1; p_res = mk_err(ERR_EOF_COMMENT); mode_next = MODE_IDLE;
                end
                else if (c == "}")
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c == "\\")
                begin
                    mode_next = MODE_CESC;
                end
            end
            MODE_CESC:
            begin
                if (!e && (c == "}" || c == "\\"))
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    p_v = 1'b1; p_res = mk_err(ERR_BAD_CESC); mode_next = MODE_IDLE;
                end
            end
            MODE_IDENT:
            begin
                if (!e && (is_let || is_dig))
                begin
                    buf_we = (32'(len_reg) < KEYWORD_MAX_LEN);
                    if (32'(len_reg) <= KEYWORD_MAX_LEN)
                    begin
                        len_next = len_reg + LW'(1);
                    end
                    p_v   = 1'b1;
                    p_res = mk_text(TOK_IDENT, c);
                end
                else
                begin
                    p_v     = 1'b1;
                    p_res   = mk_tok(kw_code);
                    go_idle = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!e && c == ".")
                begin
                    if (base_reg != BASE_DEC)
                    begin
                        p_v = 1'b1; p_res = mk_err(ERR_REAL_BASE); mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        frac_next = '0; fcnt_next = '0; mode_next = MODE_REAL;
                    end
                end
                else if (!e && (is_let || is_dig))
                begin
                    if ({1'b0, digit} >= {2'b00, radix})
                    begin
                        p_v = 1'b1; p_res = mk_err(ERR_BAD_DIGIT); mode_next = MODE_IDLE;
                    end
                    else if (wide[VW+4:VW] != '0)
                    begin
                        value_next = '1;
                    end
                    else
                    begin
                        value_next = wide[VW-1:0];
                    end
                end
                else
                begin
                    p_v             = 1'b1;
                    p_res           = mk_tok(TOK_NUMB);
                    p_res.int_value = 32'(value_reg);
                    go_idle         = 1'b1;
                end
            end
            MODE_REAL:
            begin
                if (!e && is_dig)
                begin
                    frac_next = frac_add; fcnt_next = fcnt_add;
                end
                else
                begin
                    p_v               = 1'b1;
                    p_res             = mk_tok(TOK_NUMBR);
                    p_res.int_value   = 32'(value_reg);
                    p_res.frac_value  = frac_reg;
                    p_res.frac_digits = fcnt_reg;
                    go_idle           = 1'b1;
                end
            end
            MODE_DOT:
            begin
                if (!e && is_dig)
                begin
                    value_next = '0;
                    base_next  = BASE_DEC;
                    frac_next  = 30'(c - "0");
                    fcnt_next  = 4'd1;
                    mode_next  = MODE_REAL;
                end
                else
                begin
                    p_v = 1'b1; p_res = mk_tok(TOK_DOT); go_idle = 1'b1;
                end
            end
            MODE_LESS:
            begin
                p_v = 1'b1;
                if (!e && c == "=")
                begin
                    p_res = mk_tok(TOK_LE); mode_next = MODE_IDLE;
                end
                else if (!e && c == ">")
                begin
                    p_res = mk_tok(TOK_NE); mode_next = MODE_IDLE;
                end
                else
                begin
                    p_res = mk_tok(TOK_LT); go_idle = 1'b1;
                end
            end
            MODE_GREATER:
            begin
                p_v = 1'b1;
                if (!e && c == "=")
                begin
                    p_res = mk_tok(TOK_GE); mode_next = MODE_IDLE;
                end
                else
                begin
                    p_res = mk_tok(TOK_GT); go_idle = 1'b1;
                end
            end
            MODE_COLON:
            begin
                p_v = 1'b1;
                if (!e && c == "=")
                begin
                    p_res = mk_tok(TOK_ASSIGN); mode_next = MODE_IDLE;
                end
                else
                begin
                    p_res = mk_tok(TOK_COLON); go_idle = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (e)
                begin
                    p_v = 1'b1; p_res = mk_err(ERR_OPEN_STRING); mode_next = MODE_IDLE;
                end
                else if (c == "\\")
                begin
                    mode_next = MODE_SESC;
                end
                else if (c == (quote_reg ? 8'h22 : 8'h27))
                begin
                    p_v = 1'b1; p_res = mk_tok(TOK_STRING); mode_next = MODE_IDLE;
                end
                else
                begin
                    p_v = 1'b1; p_res = mk_text(TOK_STRING, c);
                end
            end
            MODE_SESC:
            begin
                p_v = 1'b1;
                if (e)
                begin
                    p_res = mk_err(ERR_OPEN_STRING); mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_STRING;
                    case (c)
                        "\\", "\"": p_res = mk_text(TOK_STRING, c);
                        "n":        p_res = mk_text(TOK_STRING, 8'd10);
                        "r":        p_res = mk_text(TOK_STRING, 8'd13);
                        "t":        p_res = mk_text(TOK_STRING, 8'd9);
                        "b":        p_res = mk_text(TOK_STRING, 8'd8);
                        default:
                        begin
                            p_res  = mk_text(TOK_STRING, "\\");
                            p2_v   = 1'b1;
                            p2_res = mk_text(TOK_STRING, c);
                        end
                    endcase
                end
            end
            default: go_idle = 1'b1;
        endcase

        // Rescan the unconsumed character from idle
        if (go_idle)
        begin
            mode_next = idle_mode;
            if (idle_quote_we)
            begin
                quote_next = idle_quote;
            end
            if (idle_ident)
            begin
                len_next = LW'(1);
                buf_we   = 1'b1;
                buf_wa   = '0;
            end
            if (idle_num)
            begin
                base_next  = idle_base;
                value_next = idle_value;
                frac_next  = '0;
                fcnt_next  = '0;
            end
        end
    end

    // Pack results into slots and mark the last one
    assign v0 = p_v || (go_idle && idle_emit);
    assign v1 = p2_v || (p_v && go_idle && idle_emit);

    always_comb
    begin
        res0 = p_v ? p_res : idle_res;
        res1 = p2_v ? p2_res : idle_res;
        res0.last = !v1;
        res1.last = 1'b1;
        res_count = {1'b0, v0} + {1'b0, v1};
    end

    // Advance scanner state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            base_reg  <= BASE_DEC;
            value_reg <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            len_reg   <= '0;
            quote_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            base_reg  <= base_next;
            value_reg <= value_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            len_reg   <= len_next;
            quote_reg <= quote_next;
        end
    end

    // Hold identifier characters for the keyword match
    always_ff @(posedge clk)
    begin
        if (fire && buf_we)
        begin
            kw_buf_reg[buf_wa] <= c;
        end
    end

endmodule

### rtl/plt_fifo.sv
// ----------------------------------------------------------------------------
// plt_fifo
// Four-entry result queue: takes up to two results a cycle, gives one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_fifo
    import plt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  plt_out_t   push0,
    input  plt_out_t   push1,
    input  logic       pop,
    output logic       head_valid,
    output plt_out_t   head,
    output logic       room
);

    plt_out_t   mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       pop_ok;

    assign head_valid = (count_reg != 3'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= 3'd2);
    assign pop_ok     = pop && head_valid;

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_count;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop_ok};
            count_reg  <= count_reg + {1'b0, push_count} - {2'b00, pop_ok};
        end
    end

endmodule

### rtl/pascal_like_tokenizer_top.sv
// ----------------------------------------------------------------------------
// pascal_like_tokenizer_top
// Streaming tokenizer for a Pascal-like language, one source byte per item.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   src     | in        | src_valid / src_ready | plt_in_t  (in_byte, end_of_input)
//   tok     | out       | tok_valid / tok_ready | plt_out_t (text or token result)
//
// One source item is processed per cycle from the input register while the
// queue has room; results land in a four-entry queue that drains one result
// a cycle while tok_ready is high. An item that yields two results leaves
// the queue one at a time, so the drain sets the rate at one result per cycle.
// An accepted item is held in the input register until its results are queued.
// Reset puts the scanner idle; the keyword buffer is left unreset.
// Processing stalls while the queue holds more than two results.
`timescale 1ns / 1ps

module pascal_like_tokenizer_top
    import plt_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  plt_in_t  src_item,
    output logic     tok_valid,
    input  logic     tok_ready,
    output plt_out_t tok_item
);

    logic       hold_valid_reg;
    plt_in_t    hold_item_reg;
    logic       room;
    logic       fire;
    plt_out_t   res0, res1;
    logic [1:0] res_count;

    assign fire      = hold_valid_reg && room;
    assign src_ready = !hold_valid_reg || fire;

    // Hold the accepted item until it is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            hold_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            hold_item_reg <= src_item;
        end
    end

    plt_scan #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (hold_item_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    plt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (fire ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (tok_ready),
        .head_valid (tok_valid),
        .head       (tok_item),
        .room       (room)
    );

endmodule

### rtl/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks on the tokenizer source and result streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plt_props
    import plt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     src_valid,
    input logic     src_ready,
    input plt_in_t  src_item,
    input logic     tok_valid,
    input logic     tok_ready,
    input plt_out_t tok_item
);

    // Hold a waiting source item
    `PLT_ASSERT_NEXT(a_src_hold, src_valid && !src_ready,
        src_valid && $stable(src_item), "src item changed while waiting")

    // Hold a stalled result
    `PLT_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready,
        tok_valid && $stable(tok_item), "tok item changed while stalled")

    // Text results carry only identifier or string type
    `PLT_ASSERT_IMPL(a_text_type, tok_valid && tok_item.is_text,
        (tok_item.token_type == TOK_IDENT || tok_item.token_type == TOK_STRING)
        && tok_item.error_code == ERR_NONE, "bad text result")

    // Error tokens carry a code
    `PLT_ASSERT_IMPL(a_err_code,
        tok_valid && tok_item.token_type == TOK_ERR && !tok_item.is_text,
        tok_item.error_code != ERR_NONE, "error token without code")

    // Other tokens carry no code
    `PLT_ASSERT_IMPL(a_no_code, tok_valid && tok_item.token_type != TOK_ERR,
        tok_item.error_code == ERR_NONE, "code on non-error result")

endmodule

bind pascal_like_tokenizer_top plt_props u_plt_props (.*);

### tb/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// Watches both channels of the tokenizer, predicts the token stream from the
// accepted source bytes and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_checker
    import plt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    input  logic     src_ready,
    input  plt_in_t  src_item,
    input  logic     tok_valid,
    input  logic     tok_ready,
    input  plt_out_t tok_item,
    output int       fail_count,
    output int       pending_count,
    output int       token_count
);

    localparam int MAX_KW = KEYWORD_MAX_LEN_DEF;
    localparam int MAX_FRAC = FRACTION_DIGITS_DEF;
    localparam logic [31:0] VALUE_SAT = 32'hFFFF_FFFF;

    scan_mode_t  mode;
    int unsigned radix;
    logic [31:0] value;
    logic [29:0] fraction;
    logic [3:0]  frac_count;
    logic [7:0]  word_chars [MAX_KW];
    int          word_len;
    logic        dquote;

    plt_out_t expected_tokens [$];
    plt_out_t step_results [$];

    // Append one result of the current item
    function automatic void emit(logic txt, logic [7:0] ch, logic [6:0] ty,
                                 logic [31:0] iv, logic [29:0] fv,
                                 logic [3:0] fd, logic [2:0] ec);
        plt_out_t r;
        r.is_text = txt; r.text_char = ch; r.token_type = ty; r.int_value = iv;
        r.frac_value = fv; r.frac_digits = fd; r.error_code = ec; r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void emit_token(logic [6:0] ty);
        emit(1'b0, 8'd0, ty, '0, '0, '0, ERR_NONE);
    endfunction

    function automatic void emit_error(logic [2:0] ec);
        emit(1'b0, 8'd0, TOK_ERR, '0, '0, '0, ec);
        mode = MODE_IDLE;
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void word_push(logic [7:0] c);
        if (word_len < MAX_KW) word_chars[word_len] = c;
        if (word_len <= MAX_KW) word_len++;
    endfunction

    // Compare the held identifier against the keyword table
    function automatic logic [6:0] keyword_code();
        bit hit;
        if (word_len > MAX_KW) return TOK_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            hit = (int'(KW_LEN[i]) == word_len);
            for (int j = 0; j < word_len && hit; j++)
                if (word_chars[j] != KW_WORD[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]) hit = 0;
            if (hit) return KW_CODE[i];
        end
        return TOK_IDENT;
    endfunction

    function automatic void begin_number(int unsigned r, logic [31:0] v);
        radix = r; value = v; fraction = '0; frac_count = '0; mode = MODE_NUMBER;
    endfunction

    function automatic void push_fraction(logic [7:0] c);
        if (frac_count < MAX_FRAC)
        begin
            fraction = fraction * 10 + (c - "0");
            frac_count++;
        end
    endfunction

    // Scan one character from the idle mode
    function automatic void scan_idle(logic [7:0] c, logic e);
        mode = MODE_IDLE;
        if (e)
        begin
            emit_token(TOK_EOI);
            return;
        end
        case (c)
            "{": mode = MODE_COMMENT;
            "[": emit_token(TOK_LBRACK);
            "]": emit_token(TOK_RBRACK);
            "&": begin_number(8, 0);
            "$": begin_number(16, 0);
            "(": emit_token(TOK_LPAREN);
            ")": emit_token(TOK_RPAREN);
            "+": emit_token(TOK_PLUS);
            "-": emit_token(TOK_MINUS);
            "*": emit_token(TOK_STAR);
            "/": emit_token(TOK_SLASH);
            ",": emit_token(TOK_COMMA);
            "=": emit_token(TOK_EQ);
            "<": mode = MODE_LESS;
            ">": mode = MODE_GREATER;
            ":": mode = MODE_COLON;
            ".": mode = MODE_DOT;
            "'":
            begin
                dquote = 0; mode = MODE_STRING;
            end
            "\"":
            begin
                dquote = 1; mode = MODE_STRING;
            end
            default:
            begin
                if (letter(c))
                begin
                    word_len = 0;
                    word_push(c);
                    emit(1'b1, c, TOK_IDENT, '0, '0, '0, ERR_NONE);
                    mode = MODE_IDENT;
                end
                else if (digit(c)) begin_number(10, 32'(c - "0"));
                else if (!(c <= " " || c == "|" || c == ";")) emit_error(ERR_BAD_CHAR);
            end
        endcase
    endfunction

    // Advance the scanner by one source item
    function automatic void predict_tokens(plt_in_t item);
        logic [7:0] c;
        logic e;
        int unsigned d;
        c = item.in_byte;
        e = item.end_of_input;
        step_results.delete();
        case (mode)
            MODE_COMMENT:
                if (e) emit_error(ERR_EOF_COMMENT);
                else if (c == "}") mode = MODE_IDLE;
                else if (c == "\\") mode = MODE_CESC;
            MODE_CESC:
                if (!e && (c == "}" || c == "\\")) mode = MODE_COMMENT;
                else emit_error(ERR_BAD_CESC);
            MODE_IDENT:
                if (!e && (letter(c) || digit(c)))
                begin
                    word_push(c);
                    emit(1'b1, c, TOK_IDENT, '0, '0, '0, ERR_NONE);
                end
                else
                begin
                    emit_token(keyword_code());
                    scan_idle(c, e);
                end
            MODE_NUMBER:
                if (!e && c == ".")
                begin
                    if (radix != 10) emit_error(ERR_REAL_BASE);
                    else
                    begin
                        fraction = '0; frac_count = '0; mode = MODE_REAL;
                    end
                end
                else if (!e && (letter(c) || digit(c)))
                begin
                    d = (c >= "a") ? c - "a" + 10 : (c >= "A") ? c - "A" + 10 : c - "0";
                    if (d >= radix) emit_error(ERR_BAD_DIGIT);
                    else if (64'(value) > (64'(VALUE_SAT) - d) / radix) value = VALUE_SAT;
                    else value = value * radix + d;
                end
                else
                begin
                    emit(1'b0, 8'd0, TOK_NUMB, value, '0, '0, ERR_NONE);
                    scan_idle(c, e);
                end
            MODE_REAL:
                if (!e && digit(c)) push_fraction(c);
                else
                begin
                    emit(1'b0, 8'd0, TOK_NUMBR, value, fraction, frac_count, ERR_NONE);
                    scan_idle(c, e);
                end
            MODE_DOT:
                if (!e && digit(c))
                begin
                    value = '0; fraction = '0; frac_count = '0; radix = 10;
                    mode = MODE_REAL;
                    push_fraction(c);
                end
                else
                begin
                    emit_token(TOK_DOT);
                    scan_idle(c, e);
                end
            MODE_LESS:
                if (!e && c == "=")
                begin
                    emit_token(TOK_LE); mode = MODE_IDLE;
                end
                else if (!e && c == ">")
                begin
                    emit_token(TOK_NE); mode = MODE_IDLE;
                end
                else
                begin
                    emit_token(TOK_LT); scan_idle(c, e);
                end
            MODE_GREATER:
                if (!e && c == "=")
                begin
                    emit_token(TOK_GE); mode = MODE_IDLE;
                end
                else
                begin
                    emit_token(TOK_GT); scan_idle(c, e);
                end
            MODE_COLON:
                if (!e && c == "=")
                begin
                    emit_token(TOK_ASSIGN); mode = MODE_IDLE;
                end
                else
                begin
                    emit_token(TOK_COLON); scan_idle(c, e);
                end
            MODE_STRING:
                if (e) emit_error(ERR_OPEN_STRING);
                else if (c == "\\") mode = MODE_SESC;
                else if (c == (dquote ? 8'h22 : 8'h27))
                begin
                    emit_token(TOK_STRING); mode = MODE_IDLE;
                end
                else emit(1'b1, c, TOK_STRING, '0, '0, '0, ERR_NONE);
            MODE_SESC:
                if (e) emit_error(ERR_OPEN_STRING);
                else
                begin
                    mode = MODE_STRING;
                    case (c)
                        "\\", "\"": emit(1'b1, c, TOK_STRING, '0, '0, '0, ERR_NONE);
                        "n": emit(1'b1, 8'd10, TOK_STRING, '0, '0, '0, ERR_NONE);
                        "r": emit(1'b1, 8'd13, TOK_STRING, '0, '0, '0, ERR_NONE);
                        "t": emit(1'b1, 8'd9, TOK_STRING, '0, '0, '0, ERR_NONE);
                        "b": emit(1'b1, 8'd8, TOK_STRING, '0, '0, '0, ERR_NONE);
                        default:
                        begin
                            emit(1'b1, "\\", TOK_STRING, '0, '0, '0, ERR_NONE);
                            emit(1'b1, c, TOK_STRING, '0, '0, '0, ERR_NONE);
                        end
                    endcase
                end
            default: scan_idle(c, e);
        endcase
        foreach (step_results[i])
        begin
            if (i == step_results.size() - 1) step_results[i].last = 1'b1;
            expected_tokens.push_back(step_results[i]);
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    task automatic check_token(plt_out_t got);
        plt_out_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("unexpected result %p", got);
            fail_count++;
            return;
        end
        want = expected_tokens.pop_front();
        token_count++;
        if (got.is_text !== want.is_text)
        begin
            $error("is_text: expected %0d, got %0d", want.is_text, got.is_text); fail_count++;
        end
        if (got.text_char !== want.text_char)
        begin
            $error("text_char: expected %0d, got %0d", want.text_char, got.text_char);
            fail_count++;
        end
        if (got.token_type !== want.token_type)
        begin
            $error("token_type: expected %0d, got %0d", want.token_type, got.token_type);
            fail_count++;
        end
        if (got.int_value !== want.int_value)
        begin
            $error("int_value: expected %0d, got %0d", want.int_value, got.int_value);
            fail_count++;
        end
        if (got.frac_value !== want.frac_value)
        begin
            $error("frac_value: expected %0d, got %0d", want.frac_value, got.frac_value);
            fail_count++;
        end
        if (got.frac_digits !== want.frac_digits)
        begin
            $error("frac_digits: expected %0d, got %0d", want.frac_digits, got.frac_digits);
            fail_count++;
        end
        if (got.error_code !== want.error_code)
        begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last); fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        token_count = 0;
        mode = MODE_IDLE; radix = 10; value = '0; fraction = '0; frac_count = '0;
        word_len = 0; dquote = 0;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && src_ready) predict_tokens(src_item);
            if (tok_valid && tok_ready) check_token(tok_item);
        end
        pending_count = expected_tokens.size();
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives source text into the tokenizer: directed fragments for each token
// kind and error, then random well-formed fragments mixed with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import plt_pkg::*;

    localparam int RANDOM_FRAGMENTS = 210;
    localparam int CYCLE_LIMIT = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_ready;
    plt_in_t  src_item = '0;
    logic     tok_valid;
    logic     tok_ready = 1'b0;
    plt_out_t tok_item;
    int       fail_count, pending_count, token_count;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       item_count = 0;

    always #2 clk = ~clk;

    pascal_like_tokenizer_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_ready(src_ready), .src_item(src_item),
        .tok_valid(tok_valid), .tok_ready(tok_ready), .tok_item(tok_item)
    );

    plt_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_ready(src_ready), .src_item(src_item),
        .tok_valid(tok_valid), .tok_ready(tok_ready), .tok_item(tok_item),
        .fail_count(fail_count), .pending_count(pending_count),
        .token_count(token_count)
    );

    // Stall the receiver on its own pattern: calm stretches and busy stretches
    always @(negedge clk)
    begin
        if (!rst_n) tok_ready <= 1'b0;
        else if ((cycle_count / 300) % 3 == 0) tok_ready <= 1'b1;
        else tok_ready <= ($urandom_range(0, 3) != 0);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Send one source item, with bursts and random gaps
    task automatic send_item(logic [7:0] c, logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        src_item <= '{in_byte: c, end_of_input: e};
        src_valid <= 1'b1;
        @(posedge clk);
        while (!src_ready) @(posedge clk);
        item_count++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Build one random fragment of source text
    task automatic send_fragment();
        string letters, digits, hexd;
        int n;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        digits = "0123456789";
        hexd = "0123456789abcdefABCDEF";
        n = $urandom_range(1, 12);
        case ($urandom_range(0, 13))
            0: send_text($sformatf("%0s", KW_WORD[$urandom_range(0, KW_COUNT - 1)]));
            1: repeat (n) send_item(pick({letters, digits}), 1'b0);
            2: repeat (n) send_item(pick(digits), 1'b0);
            3:
            begin
                send_item("&", 1'b0);
                repeat (n) send_item(pick("01234567"), 1'b0);
            end
            4:
            begin
                send_item("$", 1'b0);
                repeat (n) send_item(pick(hexd), 1'b0);
            end
            5:
            begin
                repeat ($urandom_range(0, 4)) send_item(pick(digits), 1'b0);
                send_item(".", 1'b0);
                repeat (n) send_item(pick(digits), 1'b0);
            end
            6: send_item(pick("<>:.=+-*/,()[]"), 1'b0);
            7:
            begin
                send_item("<", 1'b0);
                send_item(pick("=>x"), 1'b0);
            end
            8:
            begin
                send_item(pick("'\""), 1'b0);
                repeat (n)
                    if ($urandom_range(0, 4) == 0)
                    begin
                        send_item("\\", 1'b0);
                        send_item(pick("\\\"nrtbq'"), 1'b0);
                    end
                    else send_item(8'($urandom_range(32, 126)), 1'b0);
                send_item(pick("'\""), 1'b0);
            end
            9:
            begin
                send_item("{", 1'b0);
                repeat (n)
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_item("\\", 1'b0);
                        send_item(pick("}\\}\\x"), 1'b0);
                    end
                    else send_item(8'($urandom_range(0, 255)), 1'b0);
                send_item("}", 1'b0);
            end
            10: send_item(pick(" \t\n;|"), 1'b0);
            11: send_item(8'($urandom_range(0, 255)), 1'b0);
            12: send_item(8'($urandom_range(0, 255)), 1'b1);
            default: send_item(pick(" ;|"), 1'b0);
        endcase
        send_item(pick(" ;|"), 1'b0);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: operators, keywords, long names, numbers, strings, comments
        send_text("< <= <> > >= : := . + - * / , = ( ) [ ] ;|");
        send_text("begin Begin enumerator enumeratorx distinct x_9 ");
        send_text("4294967295 99999999999 &777 &8 $FfA0 $g & $ 1.5 3.1234567890123 .7 ");
        send_text("&7.1 'a\\nb\\q\\\\\\\"' \"it's\" {c\\}\\\\ x} ~ ");
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hAA, 1'b1);
        send_text("{\\"); send_item(8'h55, 1'b1);
        send_text("{ab"); send_item(8'h00, 1'b1);
        send_text("{\\q 'ab"); send_item(8'h00, 1'b1);
        send_text("\"a\\"); send_item(8'h00, 1'b1);
        send_text("abc"); send_item(8'h00, 1'b1);

        // Random fragments
        repeat (RANDOM_FRAGMENTS) send_fragment();
        send_item(8'h00, 1'b1);
        src_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d source items, checked %0d results.", item_count, token_count);
        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
